[design/particle_pool_next_fit_assert.svh]
// Assertion macros for the particle pool.
// Both sample on clk and are disabled while rst_n is low.
`ifndef PARTICLE_POOL_NEXT_FIT_ASSERT_SVH
`define PARTICLE_POOL_NEXT_FIT_ASSERT_SVH

// same-cycle implication
`define PPNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPNF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ppnf_pkg.sv]
`timescale 1ns / 1ps
package ppnf_pkg;

  // default pool depth
  localparam int MAX_SLOTS_DEF = 64;

  // field widths
  localparam int SLOT_W    = 6;
  localparam int LIFE_W    = 16;
  localparam int DEC_W     = 23;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int ACT_W     = 7;

  localparam logic [LIFE_W-1:0] LIFE_FULL = 16'h8000;

  // item modes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_DRAW = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 4'd1;

  // reset values
  localparam logic [15:0]      DECAY_RATE_RST   = 16'd256;
  localparam logic [ACT_W-1:0] ACTIVE_COUNT_RST = 7'd64;

  // stored particle payload
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        size;
    logic [31:0]        color;
  } ppnf_payload_t;

  // store access request
  typedef struct packed {
    logic              life_we;
    logic              pay_we;
    logic              re;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
  } ppnf_mem_req_t;

endpackage

[design/ppnf_in_if.sv]
`timescale 1ns / 1ps
interface ppnf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        size;
  logic [31:0]        color;
  logic [15:0]        delta_time;

  modport source (output valid, mode, pos_x, pos_y, size, color, delta_time,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, size, color, delta_time,
                output ready);
endinterface

[design/ppnf_out_if.sv]
`timescale 1ns / 1ps
interface ppnf_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         slot;
  logic               pool_full;
  logic               has_particle;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [15:0]        out_size;
  logic [31:0]        out_color;
  logic               last;

  modport source (output valid, slot, pool_full, has_particle, out_x, out_y,
                  out_size, out_color, last, input ready);
  modport sink (input valid, slot, pool_full, has_particle, out_x, out_y,
                out_size, out_color, last, output ready);
endinterface

[design/ppnf_cfg_if.sv]
`timescale 1ns / 1ps
interface ppnf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppnf_pkg::CFG_IDX_W-1:0] index;
  logic [ppnf_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/ppnf_decay_unit.sv]
`timescale 1ns / 1ps
// Per-tick decrement register and the shared saturating life subtractor.
module ppnf_decay_unit (
  input  logic                        clk,
  input  logic                        load,
  input  logic [15:0]                 decay_rate,
  input  logic [15:0]                 delta_time,
  input  logic [ppnf_pkg::LIFE_W-1:0] life_in,
  output logic [ppnf_pkg::LIFE_W-1:0] life_out
);

  logic [31:0]                dec_prod;
  logic [ppnf_pkg::DEC_W-1:0] dec_r;

  // decrement = (rate * dt) >> 9, captured once per tick item
  assign dec_prod = 32'(decay_rate) * 32'(delta_time);

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r <= dec_prod[31:9];
    end
  end

  // life minus decrement, clamped at zero
  always_comb begin
    if (ppnf_pkg::DEC_W'(life_in) > dec_r) begin
      life_out = life_in - dec_r[ppnf_pkg::LIFE_W-1:0];
    end else begin
      life_out = '0;
    end
  end

endmodule

[design/ppnf_store.sv]
`timescale 1ns / 1ps
// Life and payload memories: one write port, one shared registered read port.
module ppnf_store #(
  parameter int MAX_SLOTS = ppnf_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  ppnf_pkg::ppnf_mem_req_t       req,
  input  logic [ppnf_pkg::LIFE_W-1:0]   wr_life,
  input  ppnf_pkg::ppnf_payload_t       wr_pay,
  output logic [ppnf_pkg::LIFE_W-1:0]   rd_life_r,
  output ppnf_pkg::ppnf_payload_t       rd_pay_r
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [ppnf_pkg::LIFE_W-1:0] life_mem [MAX_SLOTS];
  ppnf_pkg::ppnf_payload_t     pay_mem  [MAX_SLOTS];
  logic [IDX_W-1:0]            waddr;
  logic [IDX_W-1:0]            raddr;

  assign waddr = req.waddr[IDX_W-1:0];
  assign raddr = req.raddr[IDX_W-1:0];

  // writes
  always_ff @(posedge clk) begin
    if (req.life_we) begin
      life_mem[waddr] <= wr_life;
    end
    if (req.pay_we) begin
      pay_mem[waddr] <= wr_pay;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_life_r <= life_mem[raddr];
      rd_pay_r  <= pay_mem[raddr];
    end
  end

endmodule

[design/particle_pool_next_fit.sv]
`timescale 1ns / 1ps
// Particle pool with next-fit slot allocation.
// in_ch carries one item per handshake: add (mode 0), tick (mode 1) or draw
// (mode 2); mode 3 is dropped. cfg_ch writes decay_rate (index 0) and
// active_count (index 1); it is always ready. It is to be written while
// idle, by the user: the block itself does not enforce this. out_ch gives
// one result per add, none per tick, and one per live slot per draw (or a
// single empty result), with last on the final one. Steps, with n active slots:
//   add : scan for a free slot from the hint up to n, then from slot zero;
//         with no free slot, slot zero is overwritten and pool_full is set.
//   tick: one life read and write-back per cycle through the
//         shared saturating subtractor.
//   draw: scan the n slots, reading the payload of each live slot.
// in_ch.ready is high only while the sequencer is idle. A stalled receiver
// holds the output register; the sequencer waits only when it has a second
// result to place there. Reset frees every slot (per-slot live flags are
// cleared), zeros the search hint and restores the registers; no
// clearing pass is needed.
module particle_pool_next_fit #(
  parameter int MAX_SLOTS = ppnf_pkg::MAX_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ppnf_in_if.sink    in_ch,
  ppnf_out_if.source out_ch,
  ppnf_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ASCAN1 = 3'd1;
  localparam logic [2:0] ST_ASCAN2 = 3'd2;
  localparam logic [2:0] ST_AWRITE = 3'd3;
  localparam logic [2:0] ST_TICK   = 3'd4;
  localparam logic [2:0] ST_DSCAN  = 3'd5;
  localparam logic [2:0] ST_DREAD  = 3'd6;

  // registers
  logic [2:0]                       st_r, st_nxt;
  logic [CNT_W-1:0]                 idx_r, idx_nxt;
  logic [MAX_SLOTS-1:0]             live_r, live_nxt;
  logic [IDX_W-1:0]                 hint_r, hint_nxt;
  logic [IDX_W-1:0]                 pick_r, pick_nxt;
  logic                             full_r, full_nxt;
  ppnf_pkg::ppnf_payload_t          new_pay_r, new_pay_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]                 pend_slot_r, pend_slot_nxt;
  ppnf_pkg::ppnf_payload_t          pend_pay_r, pend_pay_nxt;
  logic                             tk_v_r, tk_v_nxt;
  logic [IDX_W-1:0]                 tk_idx_r, tk_idx_nxt;
  logic [15:0]                      decay_r;
  logic [ppnf_pkg::ACT_W-1:0]       active_r;
  logic                             out_v_r, out_v_nxt;
  logic [ppnf_pkg::SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                             out_full_r, out_full_nxt;
  logic                             out_has_r, out_has_nxt;
  logic                             out_last_r, out_last_nxt;
  ppnf_pkg::ppnf_payload_t          out_pay_r, out_pay_nxt;

  // combinational
  logic [CNT_W-1:0]                 n_used;
  logic [IDX_W-1:0]                 idx_lo;
  logic                             idx_end;
  logic                             in_rdy;
  logic                             in_acc;
  logic                             out_free;
  logic                             dec_load;
  ppnf_pkg::ppnf_payload_t          in_pay;
  ppnf_pkg::ppnf_mem_req_t          mreq;
  logic [ppnf_pkg::LIFE_W-1:0]      wr_life;
  logic [ppnf_pkg::LIFE_W-1:0]      rd_life;
  logic [ppnf_pkg::LIFE_W-1:0]      tick_life;
  ppnf_pkg::ppnf_payload_t          rd_pay;

  assign in_rdy   = (st_r == ST_IDLE);
  assign in_acc   = in_ch.valid && in_rdy;
  assign out_free = !out_v_r || out_ch.ready;
  assign idx_lo   = idx_r[IDX_W-1:0];
  assign idx_end  = (idx_r >= n_used);
  assign dec_load = in_acc && (in_ch.mode == ppnf_pkg::MODE_TICK);

  assign in_pay.x     = in_ch.pos_x;
  assign in_pay.y     = in_ch.pos_y;
  assign in_pay.size  = in_ch.size;
  assign in_pay.color = in_ch.color;

  // effective slot count: zero acts as one, clamp at pool depth
  always_comb begin
    if (active_r == '0) begin
      n_used = CNT_W'(1);
    end else if (active_r > ppnf_pkg::ACT_W'(MAX_SLOTS)) begin
      n_used = CNT_W'(MAX_SLOTS);
    end else begin
      n_used = CNT_W'(active_r);
    end
  end

  ppnf_decay_unit u_decay (
    .clk        (clk),
    .load       (dec_load),
    .decay_rate (decay_r),
    .delta_time (in_ch.delta_time),
    .life_in    (rd_life),
    .life_out   (tick_life)
  );

  ppnf_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
    .clk       (clk),
    .req       (mreq),
    .wr_life   (wr_life),
    .wr_pay    (new_pay_r),
    .rd_life_r (rd_life),
    .rd_pay_r  (rd_pay)
  );

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    live_nxt      = live_r;
    hint_nxt      = hint_r;
    pick_nxt      = pick_r;
    full_nxt      = full_r;
    new_pay_nxt   = new_pay_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_pay_nxt  = pend_pay_r;
    tk_v_nxt      = 1'b0;
    tk_idx_nxt    = tk_idx_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_slot_nxt  = out_slot_r;
    out_full_nxt  = out_full_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_pay_nxt   = out_pay_r;
    mreq          = '0;
    wr_life       = tick_life;

    // tick write-back stage, one slot behind the read
    if (tk_v_r) begin
      mreq.life_we = 1'b1;
      mreq.waddr   = ppnf_pkg::SLOT_W'(tk_idx_r);
      if (tick_life == '0) begin
        live_nxt[tk_idx_r] = 1'b0;
      end
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            ppnf_pkg::MODE_ADD: begin
              new_pay_nxt = in_pay;
              if (CNT_W'(hint_r) < n_used) begin
                idx_nxt = CNT_W'(hint_r);
                st_nxt  = ST_ASCAN1;
              end else begin
                idx_nxt = '0;
                st_nxt  = ST_ASCAN2;
              end
            end
            ppnf_pkg::MODE_TICK: begin
              idx_nxt = '0;
              st_nxt  = ST_TICK;
            end
            ppnf_pkg::MODE_DRAW: begin
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              st_nxt     = ST_DSCAN;
            end
            default: begin
              st_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // next-fit search, first from the hint
      ST_ASCAN1: begin
        if (idx_end) begin
          idx_nxt = '0;
          st_nxt  = ST_ASCAN2;
        end else if (!live_r[idx_lo]) begin
          pick_nxt = idx_lo;
          full_nxt = 1'b0;
          st_nxt   = ST_AWRITE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // then from slot zero; no free slot overwrites slot zero
      ST_ASCAN2: begin
        if (idx_end) begin
          pick_nxt = '0;
          full_nxt = 1'b1;
          st_nxt   = ST_AWRITE;
        end else if (!live_r[idx_lo]) begin
          pick_nxt = idx_lo;
          full_nxt = 1'b0;
          st_nxt   = ST_AWRITE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_AWRITE: begin
        if (out_free) begin
          mreq.life_we     = 1'b1;
          mreq.pay_we      = 1'b1;
          mreq.waddr       = ppnf_pkg::SLOT_W'(pick_r);
          wr_life          = ppnf_pkg::LIFE_FULL;
          live_nxt[pick_r] = 1'b1;
          if (!full_r) begin
            hint_nxt = pick_r;
          end
          out_v_nxt    = 1'b1;
          out_slot_nxt = ppnf_pkg::SLOT_W'(pick_r);
          out_full_nxt = full_r;
          out_has_nxt  = 1'b0;
          out_last_nxt = 1'b1;
          out_pay_nxt  = '0;
          st_nxt       = ST_IDLE;
        end
      end

      // read one slot per cycle; write-back follows in the next cycle
      ST_TICK: begin
        if (idx_end) begin
          st_nxt = ST_IDLE;
        end else begin
          mreq.re    = 1'b1;
          mreq.raddr = ppnf_pkg::SLOT_W'(idx_lo);
          tk_v_nxt   = live_r[idx_lo];
          tk_idx_nxt = idx_lo;
          idx_nxt    = idx_r + 1'b1;
        end
      end

      // draw: one live slot is held back until the next is known
      ST_DSCAN: begin
        if (idx_end) begin
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_full_nxt = 1'b0;
            out_last_nxt = 1'b1;
            out_has_nxt  = pend_v_r;
            if (pend_v_r) begin
              out_slot_nxt = ppnf_pkg::SLOT_W'(pend_slot_r);
              out_pay_nxt  = pend_pay_r;
            end else begin
              out_slot_nxt = '0;
              out_pay_nxt  = '0;
            end
            pend_v_nxt = 1'b0;
            st_nxt     = ST_IDLE;
          end
        end else if (live_r[idx_lo]) begin
          mreq.re    = 1'b1;
          mreq.raddr = ppnf_pkg::SLOT_W'(idx_lo);
          st_nxt     = ST_DREAD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_DREAD: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_slot_nxt = ppnf_pkg::SLOT_W'(pend_slot_r);
            out_full_nxt = 1'b0;
            out_has_nxt  = 1'b1;
            out_last_nxt = 1'b0;
            out_pay_nxt  = pend_pay_r;
          end
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = idx_lo;
          pend_pay_nxt  = rd_pay;
          idx_nxt       = idx_r + 1'b1;
          st_nxt        = ST_DSCAN;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      live_r   <= '0;
      hint_r   <= '0;
      pend_v_r <= 1'b0;
      tk_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      live_r   <= live_nxt;
      hint_r   <= hint_nxt;
      pend_v_r <= pend_v_nxt;
      tk_v_r   <= tk_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pick_r      <= pick_nxt;
    full_r      <= full_nxt;
    new_pay_r   <= new_pay_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_pay_r  <= pend_pay_nxt;
    tk_idx_r    <= tk_idx_nxt;
    out_slot_r  <= out_slot_nxt;
    out_full_r  <= out_full_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_pay_r   <= out_pay_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= ppnf_pkg::DECAY_RATE_RST;
      active_r <= ppnf_pkg::ACTIVE_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ppnf_pkg::REG_DECAY_RATE: begin
          decay_r <= cfg_ch.data;
        end
        ppnf_pkg::REG_ACTIVE_COUNT: begin
          active_r <= cfg_ch.data[ppnf_pkg::ACT_W-1:0];
        end
        default: begin
          decay_r <= decay_r;
        end
      endcase
    end
  end

  // ports
  assign in_ch.ready         = in_rdy;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_v_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.pool_full    = out_full_r;
  assign out_ch.has_particle = out_has_r;
  assign out_ch.out_x        = out_pay_r.x;
  assign out_ch.out_y        = out_pay_r.y;
  assign out_ch.out_size     = out_pay_r.size;
  assign out_ch.out_color    = out_pay_r.color;
  assign out_ch.last         = out_last_r;

`include "particle_pool_next_fit_assert.svh"

  `PPNF_ASSERT_IMP(a_idle_no_writeback, in_rdy, !tk_v_r, "tick write-back pending while idle")
  `PPNF_ASSERT_IMP(a_draw_not_full, out_v_r && out_has_r, !out_full_r, "drawn item flagged full")
  `PPNF_ASSERT_NXT(a_add_busy, in_acc && (in_ch.mode == ppnf_pkg::MODE_ADD), !in_rdy, "add not busy")

endmodule

[bench/particle_pool_next_fit_tb.sv]
`timescale 1ns / 1ps
module particle_pool_next_fit_tb;

  localparam int POOL_SLOTS      = ppnf_pkg::MAX_SLOTS_DEF;
  localparam int SETTLE_CYCLES   = 2 * POOL_SLOTS + 8;
  localparam int QUIET_LIMIT     = 4000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 54;

  // mode 3 has no name in the package; the pool drops it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // register indexes with nothing behind them
  localparam logic [ppnf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd2;
  localparam logic [ppnf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'hF;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size;
    logic [31:0]        color;
    logic [15:0]        delta_time;
  } pool_item_t;

  typedef struct packed {
    logic [ppnf_pkg::SLOT_W-1:0] slot;
    logic                        pool_full;
    logic                        has_particle;
    logic signed [15:0]          x;
    logic signed [15:0]          y;
    logic [15:0]                 size;
    logic [31:0]                 color;
    logic                        last;
  } slot_result_t;

  // Shadow of the pool: registers, slot store, hint and the results still due
  class pool_tracker;
    logic [15:0]                 decay_rate;
    logic [ppnf_pkg::ACT_W-1:0]  active_count;
    logic [ppnf_pkg::LIFE_W-1:0] life [POOL_SLOTS];
    ppnf_pkg::ppnf_payload_t     particle [POOL_SLOTS];
    int                          hint;
    slot_result_t                due_q[$];
    int                          errors;

    function new();
      decay_rate   = ppnf_pkg::DECAY_RATE_RST;
      active_count = ppnf_pkg::ACTIVE_COUNT_RST;
      foreach (life[i]) life[i] = '0;
      hint   = 0;
      errors = 0;
    endfunction

    function void write_register(logic [ppnf_pkg::CFG_IDX_W-1:0] idx,
                                 logic [ppnf_pkg::CFG_DAT_W-1:0] data);
      case (idx)
        ppnf_pkg::REG_DECAY_RATE:   decay_rate = data;
        ppnf_pkg::REG_ACTIVE_COUNT: active_count = data[ppnf_pkg::ACT_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the pool as the whole pool
    function int slots_in_use();
      int n;
      n = active_count;
      if (n == 0) n = 1;
      if (n > POOL_SLOTS) n = POOL_SLOTS;
      return n;
    endfunction

    function void apply_item(pool_item_t it);
      int                         n;
      int                         i;
      int                         pick;
      bit                         found;
      bit                         have_prev;
      logic [31:0]                prod;
      logic [ppnf_pkg::DEC_W-1:0] dec;
      slot_result_t               r;
      slot_result_t               prev;
      n = slots_in_use();
      case (it.mode)
        ppnf_pkg::MODE_ADD: begin
          // next fit: hint up to the end, then wrap to slot zero
          found = 0;
          pick  = 0;
          for (i = hint; i < n && !found; i++) begin
            if (life[i] == '0) begin
              pick  = i;
              found = 1;
            end
          end
          for (i = 0; i < n && !found; i++) begin
            if (life[i] == '0) begin
              pick  = i;
              found = 1;
            end
          end
          if (found) hint = pick;
          life[pick]           = ppnf_pkg::LIFE_FULL;
          particle[pick].x     = it.pos_x;
          particle[pick].y     = it.pos_y;
          particle[pick].size  = it.size;
          particle[pick].color = it.color;
          r           = '0;
          r.slot      = pick[ppnf_pkg::SLOT_W-1:0];
          r.pool_full = !found;
          r.last      = 1'b1;
          due_q.push_back(r);
        end
        ppnf_pkg::MODE_TICK: begin
          // decrement can run past 16 bits; life saturates at zero
          prod = {16'd0, decay_rate} * {16'd0, it.delta_time};
          dec  = prod[ppnf_pkg::DEC_W+8:9];
          for (i = 0; i < n; i++) begin
            if (life[i] != '0) begin
              if (dec >= {{(ppnf_pkg::DEC_W-ppnf_pkg::LIFE_W){1'b0}}, life[i]})
                life[i] = '0;
              else life[i] = life[i] - dec[ppnf_pkg::LIFE_W-1:0];
            end
          end
        end
        ppnf_pkg::MODE_DRAW: begin
          // hold one result back so that the final one can carry last
          have_prev = 0;
          prev      = '0;
          for (i = 0; i < n; i++) begin
            if (life[i] != '0) begin
              if (have_prev) due_q.push_back(prev);
              prev              = '0;
              prev.slot         = i[ppnf_pkg::SLOT_W-1:0];
              prev.has_particle = 1'b1;
              prev.x            = particle[i].x;
              prev.y            = particle[i].y;
              prev.size         = particle[i].size;
              prev.color        = particle[i].color;
              have_prev         = 1;
            end
          end
          // empty pool still answers with a single blank result
          prev.last = 1'b1;
          due_q.push_back(prev);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_slot_result(slot_result_t got);
      slot_result_t exp;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result, slot %0d", got.slot));
      end else begin
        exp = due_q.pop_front();
        if (got.slot !== exp.slot)
          report($sformatf("slot %0d, want %0d", got.slot, exp.slot));
        if (got.pool_full !== exp.pool_full)
          report($sformatf("pool_full %b, want %b", got.pool_full, exp.pool_full));
        if (got.has_particle !== exp.has_particle)
          report($sformatf("has_particle %b, want %b", got.has_particle, exp.has_particle));
        if (got.x !== exp.x)
          report($sformatf("out_x %h, want %h (slot %0d)", got.x, exp.x, exp.slot));
        if (got.y !== exp.y)
          report($sformatf("out_y %h, want %h (slot %0d)", got.y, exp.y, exp.slot));
        if (got.size !== exp.size)
          report($sformatf("out_size %h, want %h (slot %0d)", got.size, exp.size, exp.slot));
        if (got.color !== exp.color)
          report($sformatf("out_color %h, want %h (slot %0d)", got.color, exp.color, exp.slot));
        if (got.last !== exp.last)
          report($sformatf("last %b, want %b (slot %0d)", got.last, exp.last, exp.slot));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;

  pool_tracker tracker = new();

  ppnf_in_if  in_ch();
  ppnf_out_if out_ch();
  ppnf_cfg_if cfg_ch();

  particle_pool_next_fit #(
    .MAX_SLOTS(POOL_SLOTS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random back-pressure, decided at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_slot_result('{slot: out_ch.slot, pool_full: out_ch.pool_full,
                                  has_particle: out_ch.has_particle, x: out_ch.out_x,
                                  y: out_ch.out_y, size: out_ch.out_size,
                                  color: out_ch.out_color, last: out_ch.last});
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function pool_item_t make_item(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] w, logic [31:0] c, logic [15:0] dt);
    pool_item_t it;
    it.mode       = mode;
    it.pos_x      = x;
    it.pos_y      = y;
    it.size       = w;
    it.color      = c;
    it.delta_time = dt;
    return it;
  endfunction

  // Mostly adds, ticks and draws; a few dropped mode-3 items
  function pool_item_t random_item();
    pool_item_t it;
    int         pick;
    pick          = $urandom_range(99);
    it.pos_x      = 16'($urandom);
    it.pos_y      = 16'($urandom);
    it.size       = 16'($urandom);
    it.color      = $urandom;
    // short steps let particles age over several ticks
    it.delta_time = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    if (pick < 48) it.mode = ppnf_pkg::MODE_ADD;
    else if (pick < 70) it.mode = ppnf_pkg::MODE_TICK;
    else if (pick < 96) it.mode = ppnf_pkg::MODE_DRAW;
    else it.mode = MODE_UNUSED;
    return it;
  endfunction

  task send_item(input pool_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= it.mode;
    in_ch.pos_x      <= it.pos_x;
    in_ch.pos_y      <= it.pos_y;
    in_ch.size       <= it.size;
    in_ch.color      <= it.color;
    in_ch.delta_time <= it.delta_time;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.apply_item(it);
  endtask

  task write_reg(input logic [ppnf_pkg::CFG_IDX_W-1:0] idx,
                 input logic [ppnf_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_register(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain all results, then give a trailing tick time to finish
  task drain_pool();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] phase_decay [PHASES];
    logic [15:0] phase_active [PHASES];
    pool_item_t  it;
    int          sent;

    rst_n            = 1'b0;
    quiet_cycles     = 0;
    send_idle_pct    = 34;
    recv_idle_pct    = 82;
    in_ch.valid      = 1'b0;
    in_ch.mode       = ppnf_pkg::MODE_ADD;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.size       = '0;
    in_ch.color      = '0;
    in_ch.delta_time = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = ppnf_pkg::REG_DECAY_RATE;
    cfg_ch.data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty draw, field extremes, ignored mode, killing tick
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_item(make_item(ppnf_pkg::MODE_ADD, 16'h8000, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF));
    send_item(make_item(ppnf_pkg::MODE_ADD, 16'h7FFF, 16'h8000, 16'h0000, 32'h0000_0000,
                        16'h0));
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                        16'hFFFF));
    send_item(make_item(ppnf_pkg::MODE_TICK, 16'h1234, 16'h5678, 16'h9ABC, 32'hDEAD_BEEF,
                        16'h0000));
    send_item(make_item(ppnf_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0100));
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_item(make_item(MODE_UNUSED, 16'hA5A5, 16'h5A5A, 16'hFFFF, 32'h1234_5678, 16'h0));
    send_item(make_item(ppnf_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'hFFFF));
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));

    // Two slots, filled past capacity; then a decrement far beyond 16 bits
    drain_pool();
    write_reg(ppnf_pkg::REG_DECAY_RATE, 16'hFFFF);
    write_reg(ppnf_pkg::REG_ACTIVE_COUNT, 16'd2);
    repeat (3) send_item(make_item(ppnf_pkg::MODE_ADD, 16'($urandom), 16'($urandom),
                                   16'($urandom), $urandom, 16'h0));
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_item(make_item(ppnf_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'hFFFF));
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));

    // Push the hint up, then shrink the pool below it
    drain_pool();
    write_reg(ppnf_pkg::REG_ACTIVE_COUNT, 16'd64);
    repeat (6) send_item(make_item(ppnf_pkg::MODE_ADD, 16'($urandom), 16'($urandom),
                                   16'($urandom), $urandom, 16'h0));
    send_item(make_item(ppnf_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 32'h0, 16'hFFFF));
    drain_pool();
    write_reg(ppnf_pkg::REG_ACTIVE_COUNT, 16'd4);
    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'h0000);
    send_item(make_item(ppnf_pkg::MODE_ADD, 16'h0010, 16'hFFF0, 16'h0040, 32'h8040_20FF,
                        16'h0));
    send_item(make_item(ppnf_pkg::MODE_DRAW, 16'h0, 16'h0, 16'h0, 32'h0, 16'h0));

    // Random phases, each under its own register setting
    phase_decay  = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd300,
                     16'($urandom), 16'($urandom_range(2000, 100))};
    phase_active = '{16'd64, 16'd3, 16'hFF82, 16'd127,
                     {9'($urandom), 7'($urandom_range(64, 1))}, 16'd0, 16'hFFC5,
                     16'($urandom_range(64, 1))};
    for (int p = 0; p < PHASES; p++) begin
      drain_pool();
      if (p < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 82;
      end else if (p < 6) begin
        send_idle_pct = 82;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(ppnf_pkg::REG_DECAY_RATE, phase_decay[p]);
      write_reg(ppnf_pkg::REG_ACTIVE_COUNT, phase_active[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        it = random_item();
        send_item(it);
        if (it.mode != MODE_UNUSED) sent++;
      end
    end

    drain_pool();
    if (tracker.errors == 0 && tracker.due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
